/* design/bm232_pkg.sv */
// Package for the binomial mod 2^32 core: sequencer state, multiplier operand codes,
// and the block constants of the odd-number product.
// No dependencies.
`default_nettype none

package bm232_pkg;

   localparam int unsigned CountBits   = 31;             // odd-count is taken mod 2^31
   localparam int unsigned BlockLog    = 15;             // 2^15 odd factors per block
   localparam int unsigned BlkCntBits  = CountBits - BlockLog;
   localparam int unsigned StepBits    = BlockLog + 1;
   localparam int unsigned NewtonSteps = 5;
   localparam int unsigned IterBits    = 3;
   localparam int unsigned TwosBits    = 33;

   localparam logic [StepBits-1:0] InitLastStep = {StepBits{1'b1}};

   typedef enum logic [11:0] {
      ST_INIT_S = 12'b0000_0000_0001,
      ST_INIT_P = 12'b0000_0000_0010,
      ST_IDLE   = 12'b0000_0000_0100,
      ST_LEVEL  = 12'b0000_0000_1000,
      ST_BLOCK  = 12'b0000_0001_0000,
      ST_REM    = 12'b0000_0010_0000,
      ST_INV_A  = 12'b0000_0100_0000,
      ST_INV_B  = 12'b0000_1000_0000,
      ST_INV_C  = 12'b0001_0000_0000,
      ST_FINAL  = 12'b0010_0000_0000,
      ST_SCALE  = 12'b0100_0000_0000,
      ST_OUT    = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      SEL_N = 2'd0,
      SEL_K = 2'd1,
      SEL_M = 2'd2
   } fact_sel_type;

   typedef enum logic [2:0] {
      MUL_NONE   = 3'd0,
      MUL_INIT_S = 3'd1,
      MUL_INIT_P = 3'd2,
      MUL_BLOCK  = 3'd3,
      MUL_REM    = 3'd4,
      MUL_INV_A  = 3'd5,
      MUL_INV_C  = 3'd6,
      MUL_FINAL  = 3'd7
   } mul_op_type;

   typedef struct packed {
      logic [31:0]         acc;
      logic [31:0]         fac;
      logic [31:0]         odd;
      logic [31:0]         blk_const;
      logic [31:0]         blk_lin;
      logic [StepBits-1:0] step;
      logic [31:0]         den;
      logic [31:0]         inv;
      logic [31:0]         corr;
      logic [31:0]         num;
   } mul_src_type;

endpackage

`default_nettype wire

/* design/bm232_mul.sv */
// Shared 32x32 multiplier (low word) with operand selection per sequencer step.
// Depends on bm232_pkg.
`default_nettype none

module bm232_mul
   import bm232_pkg::*;
(
   input  mul_op_type  op,
   input  mul_src_type src,
   output logic [31:0] product
);

   logic [31:0] a_w;
   logic [31:0] b_w;

   always_comb begin
      unique case (op)
         MUL_INIT_S: begin
            a_w = src.blk_lin;
            b_w = 32'(src.step);
         end
         MUL_INIT_P: begin
            a_w = src.blk_const;
            b_w = 32'(src.step);
         end
         MUL_BLOCK: begin
            a_w = src.acc;
            b_w = src.fac;
         end
         MUL_REM: begin
            a_w = src.acc;
            b_w = src.odd;
         end
         MUL_INV_A: begin
            a_w = src.den;
            b_w = src.inv;
         end
         MUL_INV_C: begin
            a_w = src.inv;
            b_w = src.corr;
         end
         MUL_FINAL: begin
            a_w = src.num;
            b_w = src.inv;
         end
         MUL_NONE: begin
            a_w = 32'd0;
            b_w = 32'd0;
         end
         default: begin
            a_w = 32'd0;
            b_w = 32'd0;
         end
      endcase
   end

   assign product = a_w * b_w;

endmodule

`default_nettype wire

/* design/binomial_mod_2_32_core.sv */
// Top level: C(n,k) mod 2^32 via odd-part factorial products on one shared multiplier.
// Depends on bm232_pkg and bm232_mul.
//
//  channel | dir | tdata                          | tuser
//  req     | in  | [31:0] n_value, [63:32] k_value | -
//  rsp     | out | [31:0] binomial_low_word       | [0] bad_argument
//
// After reset the block constants are built in ST_INIT_S and ST_INIT_P; req_tready stays low.
// Each odd factor or block of 2^15 odd factors takes one multiplication in ST_REM or ST_BLOCK,
// plus a pass through ST_LEVEL per level; k above n goes straight to the result.
// One item at a time; req_tready is high only when idle, and a result holds until taken.
`default_nettype none

module binomial_mod_2_32_core
   import bm232_pkg::*;
#(
   parameter int unsigned ARG_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] n_value, [63:32] k_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] binomial_low_word
   output logic             rsp_tuser    // [0] bad_argument
);

   localparam logic [31:0] ArgMask = (ARG_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << ARG_BITS) - 64'd1);

   state_type             state_ff, state_in;
   fact_sel_type          sel_ff, sel_in;
   logic [31:0]           n_ff, n_in, k_ff, k_in, x_ff, x_in;
   logic [31:0]           num_ff, num_in, den_ff, den_in;
   logic [31:0]           fac_ff, fac_in, odd_ff, odd_in;
   logic [31:0]           blk_const_ff, blk_const_in, blk_lin_ff, blk_lin_in;
   logic [StepBits-1:0]   step_ff, step_in;
   logic [TwosBits-1:0]   tz_ff, tz_in;
   logic [BlkCntBits-1:0] cnt_blk_ff, cnt_blk_in;
   logic [BlockLog-1:0]   cnt_rem_ff, cnt_rem_in;
   logic [31:0]           inv_ff, inv_in, corr_ff, corr_in, res_ff, res_in;
   logic [IterBits-1:0]   iter_ff, iter_in;
   logic                  bad_ff, bad_in;

   mul_op_type  mul_op;
   mul_src_type mul_src;
   logic [31:0] product;
   logic [32:0] x_plus_one;
   logic [CountBits-1:0] odd_count;
   logic [31:0] n_req, k_req;
   logic [TwosBits-1:0] half_x;

   bm232_mul u_mul (
      .op      (mul_op),
      .src     (mul_src),
      .product (product)
   );

   assign x_plus_one = {1'b0, x_ff} + 33'd1;
   assign odd_count  = x_plus_one[CountBits:1];
   assign half_x     = TwosBits'(x_ff[31:1]);
   assign n_req      = req_tdata[31:0] & ArgMask;
   assign k_req      = req_tdata[63:32] & ArgMask;

   always_comb begin
      mul_src.acc       = (sel_ff == SEL_N) ? num_ff : den_ff;
      mul_src.fac       = fac_ff;
      mul_src.odd       = odd_ff;
      mul_src.blk_const = blk_const_ff;
      mul_src.blk_lin   = blk_lin_ff;
      mul_src.step      = step_ff;
      mul_src.den       = den_ff;
      mul_src.inv       = inv_ff;
      mul_src.corr      = corr_ff;
      mul_src.num       = num_ff;
      unique case (state_ff)
         ST_INIT_S: mul_op = MUL_INIT_S;
         ST_INIT_P: mul_op = MUL_INIT_P;
         ST_BLOCK:  mul_op = MUL_BLOCK;
         ST_REM:    mul_op = MUL_REM;
         ST_INV_A:  mul_op = MUL_INV_A;
         ST_INV_C:  mul_op = MUL_INV_C;
         ST_FINAL:  mul_op = MUL_FINAL;
         default:   mul_op = MUL_NONE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      fac_in       = fac_ff;
      odd_in       = odd_ff;
      blk_const_in = blk_const_ff;
      blk_lin_in   = blk_lin_ff;
      step_in      = step_ff;
      tz_in        = tz_ff;
      cnt_blk_in   = cnt_blk_ff;
      cnt_rem_in   = cnt_rem_ff;
      inv_in       = inv_ff;
      corr_in      = corr_ff;
      res_in       = res_ff;
      iter_in      = iter_ff;
      bad_in       = bad_ff;
      unique case (state_ff)
         ST_INIT_S: begin
            corr_in  = product;
            state_in = ST_INIT_P;
         end
         ST_INIT_P: begin
            blk_const_in = product;
            blk_lin_in   = blk_const_ff + corr_ff;
            step_in      = step_ff + StepBits'(2);
            state_in     = (step_ff == InitLastStep) ? ST_IDLE : ST_INIT_S;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (k_req > n_req) begin
                  res_in   = 32'd0;
                  bad_in   = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  n_in     = n_req;
                  k_in     = k_req;
                  x_in     = n_req;
                  sel_in   = SEL_N;
                  num_in   = 32'd1;
                  den_in   = 32'd1;
                  tz_in    = '0;
                  bad_in   = 1'b0;
                  state_in = ST_LEVEL;
               end
            end
         end
         ST_LEVEL: begin
            if (x_ff == 32'd0) begin
               unique case (sel_ff)
                  SEL_N: begin
                     x_in   = k_ff;
                     sel_in = SEL_K;
                  end
                  SEL_K: begin
                     x_in   = n_ff - k_ff;
                     sel_in = SEL_M;
                  end
                  SEL_M: begin
                     inv_in   = den_ff;
                     iter_in  = '0;
                     state_in = ST_INV_A;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end else begin
               cnt_blk_in = odd_count[CountBits-1:BlockLog];
               cnt_rem_in = odd_count[BlockLog-1:0];
               fac_in     = blk_const_ff;
               odd_in     = (32'(odd_count[CountBits-1:BlockLog]) << StepBits) | 32'd1;
               x_in       = {1'b0, x_ff[31:1]};
               tz_in      = (sel_ff == SEL_N) ? tz_ff + half_x : tz_ff - half_x;
               state_in   = ST_BLOCK;
            end
         end
         ST_BLOCK: begin
            if (cnt_blk_ff == '0) begin
               state_in = ST_REM;
            end else begin
               if (sel_ff == SEL_N) num_in = product;
               else                 den_in = product;
               fac_in     = fac_ff + (blk_lin_ff << StepBits);
               cnt_blk_in = cnt_blk_ff - BlkCntBits'(1);
            end
         end
         ST_REM: begin
            if (cnt_rem_ff == '0) begin
               state_in = ST_LEVEL;
            end else begin
               if (sel_ff == SEL_N) num_in = product;
               else                 den_in = product;
               odd_in     = odd_ff + 32'd2;
               cnt_rem_in = cnt_rem_ff - BlockLog'(1);
            end
         end
         ST_INV_A: begin
            corr_in  = product;
            state_in = ST_INV_B;
         end
         ST_INV_B: begin
            corr_in  = 32'd2 - corr_ff;
            state_in = ST_INV_C;
         end
         ST_INV_C: begin
            inv_in   = product;
            iter_in  = iter_ff + IterBits'(1);
            state_in = (iter_ff == IterBits'(NewtonSteps - 1)) ? ST_FINAL : ST_INV_A;
         end
         ST_FINAL: begin
            res_in   = product;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            // exponent of two at or above the word size clears the word
            res_in   = (|tz_ff[TwosBits-1:5]) ? 32'd0 : (res_ff << tz_ff[4:0]);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_S;
         sel_ff       <= SEL_N;
         blk_const_ff <= 32'd1;
         blk_lin_ff   <= 32'd0;
         step_ff      <= StepBits'(1);
         iter_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         blk_const_ff <= blk_const_in;
         blk_lin_ff   <= blk_lin_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         x_ff         <= x_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
         fac_ff       <= fac_in;
         odd_ff       <= odd_in;
         tz_ff        <= tz_in;
         cnt_blk_ff   <= cnt_blk_in;
         cnt_rem_ff   <= cnt_rem_in;
         inv_ff       <= inv_in;
         corr_ff      <= corr_in;
         res_ff       <= res_in;
         bad_ff       <= bad_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = res_ff;
   assign rsp_tuser  = bad_ff;

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("ready while a result is pending");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 32'd0))
      else $error("bad argument with nonzero word");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready straight after a transfer");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> (req_tready && !rsp_tvalid))
      else $error("not idle after result transfer");

   a_bad_needs_order: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (k_req > n_req)) |=> (rsp_tvalid && rsp_tuser))
      else $error("k above n not flagged at once");

endmodule

`default_nettype wire

/* tb/binomial_mod_2_32_core_test.sv */
// Self-checking testbench for binomial_mod_2_32_core: directed and random (n, k) queries,
// each result checked against a local C(n,k) mod 2^32 predictor under varied idling.
// Depends on the binomial_mod_2_32_core RTL only.
`timescale 1ns / 1ps

module binomial_mod_2_32_core_test;

   localparam int unsigned CycleLimit = 40_000_000;
   localparam int unsigned DrainCycles = 20;

   typedef struct packed {
      logic [31:0] low_word;
      logic        bad_argument;
   } binomial_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   binomial_type expected_binomials[$];
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;

   // odd-number block of 2^15 factors: product = block_base + y * block_slope (y = 2^16 * b)
   bit [31:0]   block_base;
   bit [31:0]   block_slope;

   binomial_mod_2_32_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout", $time);
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      binomial_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_binomials.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual word %h bad %b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_binomials.pop_front();
            if (rsp_tdata !== want.low_word) begin
               $display("%0t: binomial_low_word expected %h actual %h",
                        $time, want.low_word, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.bad_argument) begin
               $display("%0t: bad_argument expected %b actual %b",
                        $time, want.bad_argument, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   task automatic build_odd_block();
      bit [31:0] prod;
      bit [31:0] lin;
      bit [31:0] j;
      prod = 32'd1;
      lin  = 32'd0;
      for (j = 1; j < 32'h10000; j += 2) begin
         lin  = prod + lin * j;
         prod = prod * j;
      end
      block_base  = prod;
      block_slope = lin;
   endtask

   // product of the first count odd numbers; the full 2^31 run wraps to 1
   function automatic bit [31:0] odd_run_product(input bit [63:0] count);
      bit [31:0] prod;
      bit [31:0] blocks;
      bit [31:0] tail;
      bit [31:0] b;
      bit [31:0] i;
      bit [31:0] y;
      prod   = 32'd1;
      blocks = {1'b0, count[30:0]} >> 15;
      tail   = {17'd0, count[14:0]};
      for (b = 0; b < blocks; b++) begin
         y    = b << 16;
         prod = prod * (block_base + y * block_slope);
      end
      for (i = 0; i < tail; i++)
         prod = prod * ((blocks << 16) + 2 * i + 1);
      return prod;
   endfunction

   function automatic bit [31:0] odd_factorial(input bit [31:0] x);
      bit [63:0] level;
      bit [31:0] prod;
      prod  = 32'd1;
      level = {32'd0, x};
      while (level != 0) begin
         prod  = prod * odd_run_product((level + 1) >> 1);
         level = level >> 1;
      end
      return prod;
   endfunction

   function automatic bit [31:0] odd_inverse(input bit [31:0] d);
      bit [31:0] v;
      v = d;
      repeat (5) v = v * (32'd2 - d * v);
      return v;
   endfunction

   function automatic binomial_type predict_binomial(input bit [31:0] n, input bit [31:0] k);
      binomial_type res;
      bit [31:0] odd_num;
      bit [31:0] odd_den;
      bit [31:0] ratio;
      int        carries;
      res = '0;
      if (k > n) begin
         res.bad_argument = 1'b1;
         return res;
      end
      odd_num = odd_factorial(n);
      odd_den = odd_factorial(k) * odd_factorial(n - k);
      ratio   = odd_num * odd_inverse(odd_den);
      // power of two in C(n,k) equals the carries in k + (n-k)
      carries = $countones(k) + $countones(n - k) - $countones(n);
      res.low_word = (carries >= 32) ? 32'd0 : (ratio << carries);
      return res;
   endfunction

   // called just after a rising edge; leaves req_tvalid high after the transfer
   task automatic send_query(input bit [31:0] n, input bit [31:0] k);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {k, n};
      do @(posedge clock); while (!req_tready);
      expected_binomials.push_back(predict_binomial(n, k));
   endtask

   task automatic test_edge_arguments();
      send_query(32'd0, 32'd0);
      send_query(32'd1, 32'd0);
      send_query(32'd1, 32'd1);
      send_query(32'd5, 32'd2);
      send_query(32'd64, 32'd32);
      send_query(32'd100, 32'd50);
      send_query(32'd65535, 32'd32768);
      send_query(32'd65536, 32'd1);
      send_query(32'hFFFF_FFFF, 32'd0);
      send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_query(32'hFFFF_FFFF, 32'd1);
      send_query(32'h8000_0000, 32'd1);
      send_query(32'h8000_0000, 32'h7FFF_FFFF);
      send_query(32'h8000_0000, 32'h4000_0000);
      send_query(32'h7FFF_FFFF, 32'h3FFF_FFFF);
   endtask

   task automatic test_k_above_n();
      send_query(32'd0, 32'd1);
      send_query(32'd0, 32'hFFFF_FFFF);
      send_query(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_query(32'h7FFF_FFFF, 32'h8000_0000);
      send_query(32'd2047, 32'd2048);
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      bit [31:0]   n;
      bit [31:0]   k;
      bit [31:0]   swap;
      int unsigned pick;
      int unsigned a;
      int unsigned s;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            n = $urandom;
            k = $urandom;
            if (k < n) begin
               swap = n;
               n    = k;
               k    = swap;
            end
            if (k == n) begin
               if (k == 0) k = 32'd1;
               else n = n - 1;
            end
         end else if (pick < 25) begin
            // large n near a power of two keeps the odd products short
            a = $urandom_range(31, 16);
            s = $urandom_range(255);
            n = (32'd1 << a) + s;
            case ($urandom_range(3))
               0: begin
                  k = $urandom_range(s);
               end
               1: begin
                  k = (32'd1 << a) + $urandom_range(s);
               end
               2: begin
                  k = 32'd0;
               end
               default: begin
                  k = n;
               end
            endcase
         end else begin
            n = $urandom_range(2047);
            k = $urandom_range(n);
         end
         send_query(n, k);
      end
   endtask

   initial begin
      build_odd_block();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_arguments();
      test_k_above_n();
      test_random_traffic(25, 0, 0);
      test_random_traffic(25, 56, 0);
      test_random_traffic(25, 0, 56);
      test_random_traffic(25, 16, 16);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_binomials.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
